@@ rtl/ps2s1_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ps2s1_pkg;

    // prefix bytes
    localparam logic [7:0] PREFIX_E0 = 8'hE0;
    localparam logic [7:0] PREFIX_E1 = 8'hE1;

    // make codes with a meaning of their own
    localparam logic [6:0] SC_TAB     = 7'h0F;
    localparam logic [6:0] SC_ENTER   = 7'h1C;
    localparam logic [6:0] SC_CTRL    = 7'h1D;
    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_SLASH   = 7'h35;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_ALT     = 7'h38;
    localparam logic [6:0] SC_CAPS    = 7'h3A;
    localparam logic [6:0] SC_NUM     = 7'h45;
    localparam logic [6:0] SC_SCROLL  = 7'h46;
    localparam logic [6:0] SC_HOME    = 7'h47;
    localparam logic [6:0] SC_UP      = 7'h48;
    localparam logic [6:0] SC_LEFT    = 7'h4B;
    localparam logic [6:0] SC_RIGHT   = 7'h4D;
    localparam logic [6:0] SC_END     = 7'h4F;
    localparam logic [6:0] SC_DOWN    = 7'h50;
    localparam logic [6:0] SC_DELETE  = 7'h53;
    localparam logic [6:0] SC_LMETA   = 7'h5B;
    localparam logic [6:0] SC_RMETA   = 7'h5C;

    // key codes for special keys; enter and slash keep their ascii values
    localparam logic [8:0] K_ENTER   = 9'h00D;
    localparam logic [8:0] K_SLASH   = 9'h02F;
    localparam logic [8:0] K_DELETE  = 9'h101;
    localparam logic [8:0] K_LEFT    = 9'h102;
    localparam logic [8:0] K_RIGHT   = 9'h103;
    localparam logic [8:0] K_HOME    = 9'h104;
    localparam logic [8:0] K_END     = 9'h105;
    localparam logic [8:0] K_UP      = 9'h106;
    localparam logic [8:0] K_DOWN    = 9'h107;
    localparam logic [8:0] K_ALT_TAB = 9'h108;
    localparam logic [8:0] K_SUPER   = 9'h109;

    localparam int TABLE_SIZE = 88;

    // us layout, no shift
    localparam logic [7:0] PLAIN_MAP [0:TABLE_SIZE-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // us layout, shift held
    localparam logic [7:0] SHIFT_MAP [0:TABLE_SIZE-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // table lookup, zero past the end of the table
    function automatic logic [7:0] map_lookup(input logic [6:0] code, input logic shifted);
        logic [7:0] c;
        c = 8'h00;
        if (code < 7'(TABLE_SIZE)) begin
            c = shifted ? SHIFT_MAP[code] : PLAIN_MAP[code];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ps2_set1_scancode_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | payload                                  | handshake
// s_axis    | in  | tdata[7:0] scan_byte                     | tvalid/tready
// m_axis    | out | tuser key_valid, tdata key event + locks | tvalid/tready
//
// one scancode byte a cycle while the result is taken; an accepted byte goes to the input register,
// then is decoded into the result register
// decoder state (modifiers, locks, prefix) moves when a byte enters the result register
// i_rst_n synchronous, clears modifiers, locks, prefix state and both valid flags
// a stalled result holds the input register; tready drops only when both are full

module ps2_set1_scancode_decoder_core
    import ps2s1_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [8:0] key_code, [12:9] modifier_bits,
                                             // [13] caps_lock_on, [14] num_lock_on,
                                             // [15] scroll_lock_on
    output logic             m_axis_tuser    // [0] key_valid
);

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_E0   = 2'd1,
        PFX_E1   = 2'd2
    } t_prefix;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_byte;

    // decoder state
    t_prefix    r_prefix, n_prefix;
    logic       r_shift, n_shift;
    logic       r_ctrl, n_ctrl;
    logic       r_alt, n_alt;
    logic       r_meta, n_meta;
    logic       r_caps, n_caps;
    logic       r_num, n_num;
    logic       r_scroll, n_scroll;

    // result stage
    logic       r_out_valid;
    logic       r_out_key_valid;
    logic [8:0] r_out_key_code;
    logic [3:0] r_out_mods;
    logic       r_out_caps, r_out_num, r_out_scroll;

    logic       w_advance;
    logic       w_brk;
    logic [6:0] w_code;
    logic [7:0] w_chr;
    logic [8:0] n_key;

    // handshake: decode moves on when the result slot is free or being taken
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    assign w_brk  = r_byte[7];
    assign w_code = r_byte[6:0];

    // decode one byte against the current state
    always_comb begin
        n_prefix = r_prefix;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_alt    = r_alt;
        n_meta   = r_meta;
        n_caps   = r_caps;
        n_num    = r_num;
        n_scroll = r_scroll;
        n_key    = '0;
        w_chr    = '0;

        if (r_byte == PREFIX_E0) begin
            n_prefix = PFX_E0;
        end else if (r_byte == PREFIX_E1) begin
            n_prefix = PFX_E1;
        end else if (r_prefix == PFX_E1) begin
            // byte after e1 is dropped
            n_prefix = PFX_NONE;
        end else if (r_prefix == PFX_E0) begin
            n_prefix = PFX_NONE;
            if (w_code == SC_CTRL) begin
                n_ctrl = !w_brk;
            end else if (w_code == SC_ALT) begin
                n_alt = !w_brk;
            end else if (w_brk) begin
                if (w_code == SC_LMETA) n_meta = 1'b0;
            end else begin
                case (w_code)
                    SC_UP:     n_key = K_UP;
                    SC_DOWN:   n_key = K_DOWN;
                    SC_RIGHT:  n_key = K_RIGHT;
                    SC_LEFT:   n_key = K_LEFT;
                    SC_DELETE: n_key = K_DELETE;
                    SC_HOME:   n_key = K_HOME;
                    SC_END:    n_key = K_END;
                    SC_ENTER:  n_key = K_ENTER;
                    SC_SLASH:  n_key = K_SLASH;
                    SC_LMETA: begin
                        n_meta = 1'b1;
                        n_key  = K_SUPER;
                    end
                    default:   n_key = '0;
                endcase
            end
        end else begin
            case (w_code)
                SC_LSHIFT, SC_RSHIFT: n_shift = !w_brk;
                SC_CTRL:              n_ctrl  = !w_brk;
                SC_ALT:               n_alt   = !w_brk;
                SC_LMETA, SC_RMETA:   n_meta  = !w_brk;
                SC_CAPS:              n_caps   = r_caps ^ !w_brk;
                SC_NUM:               n_num    = r_num ^ !w_brk;
                SC_SCROLL:            n_scroll = r_scroll ^ !w_brk;
                default: begin
                    if (!w_brk) begin
                        if (w_code == SC_TAB && r_alt) begin
                            n_key = K_ALT_TAB;
                        end else begin
                            w_chr = map_lookup(w_code, r_shift);
                            // caps lock swaps letter case
                            if (r_caps && (w_chr inside {[8'h61:8'h7A], [8'h41:8'h5A]})) begin
                                w_chr = w_chr ^ 8'h20;
                            end
                            // ctrl with a letter gives 1..26
                            if (r_ctrl && (w_chr inside {[8'h61:8'h7A], [8'h41:8'h5A]})) begin
                                n_key = {4'b0000, w_chr[4:0]};
                            end else begin
                                n_key = {1'b0, w_chr};
                            end
                        end
                    end
                end
            endcase
        end
    end

    // state, input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prefix    <= PFX_NONE;
            r_shift     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
            r_meta      <= 1'b0;
            r_caps      <= 1'b0;
            r_num       <= 1'b0;
            r_scroll    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
                r_byte     <= s_axis_tdata;
            end
            if (w_advance) begin
                r_out_valid     <= 1'b1;
                r_out_key_valid <= (n_key != '0);
                r_out_key_code  <= n_key;
                r_out_mods      <= {n_meta, n_alt, n_ctrl, n_shift};
                r_out_caps      <= n_caps;
                r_out_num       <= n_num;
                r_out_scroll    <= n_scroll;
                r_prefix        <= n_prefix;
                r_shift         <= n_shift;
                r_ctrl          <= n_ctrl;
                r_alt           <= n_alt;
                r_meta          <= n_meta;
                r_caps          <= n_caps;
                r_num           <= n_num;
                r_scroll        <= n_scroll;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_key_valid;
    assign m_axis_tdata  = {r_out_scroll, r_out_num, r_out_caps, r_out_mods, r_out_key_code};

    // flag and code agree
    a_valid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_key_valid == (r_out_key_code != 9'd0)))
        else $error("key_valid disagrees with key_code");

    // no state change while the result is stalled
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(r_out_mods) && $stable(r_prefix)))
        else $error("decoder state moved during a stall");

    // e0 always arms the extended prefix
    a_e0_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_byte == PREFIX_E0) |=> (r_prefix == PFX_E0 && !r_out_key_valid))
        else $error("e0 did not arm the prefix");

    // byte after e1 is swallowed
    a_e1_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_prefix == PFX_E1 && r_byte != PREFIX_E0 && r_byte != PREFIX_E1)
        |=> (r_prefix == PFX_NONE && !r_out_key_valid))
        else $error("byte after e1 not dropped");

    // a held input stage refuses new requests
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |-> !s_axis_tready)
        else $error("request taken while input stage is full");

endmodule

`default_nettype wire
